/* sv/dfw_pkg.sv */
// ----------------------------------------------------------------------------
// dfw_pkg
// Shared types and constants of the dead flag-write filter.
// ----------------------------------------------------------------------------
`default_nettype none

package dfw_pkg;

  localparam int unsigned NUM_FLAGS_DEF = 16;
  localparam int unsigned ID_BITS_DEF   = 16;

  localparam int unsigned KIND_W = 2;
  localparam int unsigned FLAG_W = 4;
  localparam int unsigned IID_W  = 16;
  localparam int unsigned OUT_W  = 16;

  typedef enum logic [KIND_W-1:0] {
    KIND_SET = 2'd0,
    KIND_GET = 2'd1,
    KIND_END = 2'd2
  } kind_e;

  // Decoded request, already qualified by the input handshake and flag range
  typedef struct packed {
    logic do_set;
    logic do_get;
    logic do_end;
  } flag_req_t;

endpackage

`default_nettype wire

/* sv/dfw_id_ram.sv */
// ----------------------------------------------------------------------------
// dfw_id_ram
// Per-flag store of the pending set id. One port, read-first, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module dfw_id_ram
  import dfw_pkg::*;
#(
  parameter int unsigned DEPTH = NUM_FLAGS_DEF,
  parameter int unsigned AW    = 4,
  parameter int unsigned DW    = ID_BITS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] addr_i,
  input  wire logic [DW-1:0] wdata_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  // Old contents come out when the same entry is rewritten in this cycle
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q <= mem[addr_i];
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* sv/dfw_flag_track.sv */
// ----------------------------------------------------------------------------
// dfw_flag_track
// Pending and read bits per flag; flags a set that overwrites an unread one.
// ----------------------------------------------------------------------------
`default_nettype none

module dfw_flag_track
  import dfw_pkg::*;
#(
  parameter int unsigned NUM_FLAGS = NUM_FLAGS_DEF,
  parameter int unsigned AW        = 4
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire flag_req_t     req_i,
  input  wire logic [AW-1:0] addr_i,
  output logic               useless_o
);

  logic [NUM_FLAGS-1:0] valid_q, valid_d;
  logic [NUM_FLAGS-1:0] read_q,  read_d;

  assign useless_o = req_i.do_set && valid_q[addr_i] && !read_q[addr_i];

  always_comb begin
    valid_d = valid_q;
    read_d  = read_q;
    priority if (req_i.do_end) begin
      valid_d = '0;
      read_d  = '0;
    end else if (req_i.do_set) begin
      valid_d[addr_i] = 1'b1;
      read_d[addr_i]  = 1'b0;
    end else if (req_i.do_get) begin
      if (valid_q[addr_i]) begin
        read_d[addr_i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      read_q  <= '0;
    end else begin
      valid_q <= valid_d;
      read_q  <= read_d;
    end
  end

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.do_end |=> (valid_q == '0) && (read_q == '0))
    else $error("end of block left a pending flag");

  a_read_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (read_q & ~valid_q) == '0)
    else $error("read bit set on a flag with no pending set");

  a_req_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({req_i.do_set, req_i.do_get, req_i.do_end}))
    else $error("more than one operation in one request");

endmodule

`default_nettype wire

/* sv/dead_flag_write_filter.sv */
// ----------------------------------------------------------------------------
// dead_flag_write_filter
// Reports flag-set instructions whose value is overwritten before any read.
// ----------------------------------------------------------------------------
// Input channel (valid_i / stall_o) carries one instruction per request:
// kind_i (set, get, end of block), flag_id_i and instr_id_i. Output channel
// (valid_o / stall_i) carries the id of a useless set, at most one per input.
// Throughput: one request per cycle while stall_o is low. The per-flag
// pending/read bits live in flops and are updated in the accept cycle;
// the set id of each flag lives in a single-port RAM that is read and
// rewritten in that same cycle (read-first), so back-to-back requests to
// one flag need no bypass. The id of a useless set passes through the RAM
// read register (p1 stage), then the output register, before valid_o rises.
// Reset clears every pending flag and empties both stages; the id RAM is not
// cleared. When the receiver stalls, the output register holds its request
// and one more result can wait in the RAM read stage; stall_o rises only
// when both are full, and then every request waits, result or not.
// ----------------------------------------------------------------------------
`default_nettype none

module dead_flag_write_filter
  import dfw_pkg::*;
#(
  parameter int unsigned NUM_FLAGS = NUM_FLAGS_DEF,
  parameter int unsigned ID_BITS   = ID_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   stall_o,
  input  wire logic [KIND_W-1:0] kind_i,
  input  wire logic [FLAG_W-1:0] flag_id_i,
  input  wire logic [IID_W-1:0]  instr_id_i,
  output logic                   valid_o,
  input  wire logic              stall_i,
  output logic      [OUT_W-1:0]  useless_set_id_o
);

  localparam int unsigned AW = (NUM_FLAGS > 1) ? $clog2(NUM_FLAGS) : 1;

  logic                 accept;
  logic                 in_range;
  logic [AW+FLAG_W-1:0] flag_ext;
  logic [AW-1:0]        addr;
  logic [ID_BITS+IID_W-1:0] wid_ext;
  logic [ID_BITS-1:0]   wid;
  logic [ID_BITS-1:0]   rid;
  logic [ID_BITS+OUT_W-1:0] rid_ext;
  flag_req_t            req;
  logic                 useless;

  logic p1_valid_q, p1_valid_d, p1_move;
  logic out_valid_q, out_valid_d;
  logic [OUT_W-1:0] out_id_q;

  assign accept   = valid_i && !stall_o;
  assign flag_ext = {{AW{1'b0}}, flag_id_i};
  assign in_range = flag_ext < (AW+FLAG_W)'(NUM_FLAGS);
  assign addr     = flag_ext[AW-1:0];
  assign wid_ext  = {{ID_BITS{1'b0}}, instr_id_i};
  assign wid      = wid_ext[ID_BITS-1:0];

  always_comb begin
    req = '0;
    if (accept) begin
      unique case (kind_i)
        KIND_SET: req.do_set = in_range;
        KIND_GET: req.do_get = in_range;
        KIND_END: req.do_end = 1'b1;
        default:  req = '0;
      endcase
    end
  end

  dfw_flag_track #(
    .NUM_FLAGS (NUM_FLAGS),
    .AW        (AW)
  ) u_track (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .addr_i    (addr),
    .useless_o (useless)
  );

  dfw_id_ram #(
    .DEPTH (NUM_FLAGS),
    .AW    (AW),
    .DW    (ID_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (req.do_set),
    .we_i    (req.do_set),
    .addr_i  (addr),
    .wdata_i (wid),
    .rdata_o (rid)
  );

  assign rid_ext = {{OUT_W{1'b0}}, rid};

  // p1 stage: RAM read data holds the overwritten id
  assign p1_move     = p1_valid_q && (!out_valid_q || !stall_i);
  assign stall_o     = p1_valid_q && !p1_move;
  assign p1_valid_d  = useless || (p1_valid_q && !p1_move);
  assign out_valid_d = p1_move || (out_valid_q && stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      p1_valid_q  <= p1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p1_move) begin
      out_id_q <= rid_ext[OUT_W-1:0];
    end
  end

  assign valid_o          = out_valid_q;
  assign useless_set_id_o = out_id_q;

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> p1_valid_q && out_valid_q && stall_i)
    else $error("input stalled with room downstream");

  a_result_from_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p1_valid_q && !$past(p1_valid_q)) |-> $past(req.do_set))
    else $error("result raised without an accepted set");

  a_p1_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p1_valid_q && !out_valid_q) |=> out_valid_q)
    else $error("pending result not moved to an empty output register");

endmodule

`default_nettype wire

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the dead flag-write filter.
// ----------------------------------------------------------------------------
// A short table of directed instructions is followed by random basic blocks:
// mostly sets and gets on a few flags, closed by an end of block, with some
// unused kinds and stray ids mixed in. A predictor in the bench tracks the
// pending set of each flag and queues the id of every overwritten unread set.
// Both channels idle at random in the first two of three phases; the third
// runs with no idling. Every result is checked in order against the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import dfw_pkg::*;

  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;  // unused code, must be ignored
  localparam int RAND_PER_PHASE = 430;
  localparam int SETTLE_CYC     = 8;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int MAX_REPORTS    = 10;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [FLAG_W-1:0] flag;
    logic [IID_W-1:0]  iid;
    bit                fixed;   // expected result typed in below
    bit                fx_hit;
    logic [OUT_W-1:0]  fx_id;
  } instr_row_t;

  logic              clk_i;
  logic              rst_ni     = 1'b0;
  logic              valid_i    = 1'b0;
  logic [KIND_W-1:0] kind_i     = '0;
  logic [FLAG_W-1:0] flag_id_i  = '0;
  logic [IID_W-1:0]  instr_id_i = '0;
  logic              stall_i    = 1'b0;
  logic              stall_o;
  logic              valid_o;
  logic [OUT_W-1:0]  useless_set_id_o;

  // predictor state
  logic [NUM_FLAGS_DEF-1:0] pend_valid = '0;
  logic [NUM_FLAGS_DEF-1:0] pend_read  = '0;
  logic [IID_W-1:0]         pend_id [NUM_FLAGS_DEF];

  logic [OUT_W-1:0] useless_ids_q [$];
  instr_row_t       directed_q [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int cyc = 0;

  dead_flag_write_filter dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (valid_i),
    .stall_o          (stall_o),
    .kind_i           (kind_i),
    .flag_id_i        (flag_id_i),
    .instr_id_i       (instr_id_i),
    .valid_o          (valid_o),
    .stall_i          (stall_i),
    .useless_set_id_o (useless_set_id_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic flag_model(input logic [KIND_W-1:0] k, input logic [FLAG_W-1:0] f,
                            input logic [IID_W-1:0] iid, output bit hit,
                            output logic [OUT_W-1:0] old_id);
    hit    = 1'b0;
    old_id = '0;
    if (k == KIND_END) begin
      pend_valid = '0;
      pend_read  = '0;
    end else if (int'(f) < NUM_FLAGS_DEF) begin
      if (k == KIND_SET) begin
        if (pend_valid[f] && !pend_read[f]) begin
          hit    = 1'b1;
          old_id = pend_id[f];
        end
        pend_valid[f] = 1'b1;
        pend_read[f]  = 1'b0;
        pend_id[f]    = iid;
      end else if (k == KIND_GET) begin
        if (pend_valid[f]) pend_read[f] = 1'b1;
      end
    end
  endtask

  // Called at a rising edge; returns at the edge where the request is taken,
  // with valid still high so the next request can follow back to back.
  task automatic send_instr(input logic [KIND_W-1:0] k, input logic [FLAG_W-1:0] f,
                            input logic [IID_W-1:0] iid, input bit fixed,
                            input bit fx_hit, input logic [OUT_W-1:0] fx_id);
    bit               hit;
    logic [OUT_W-1:0] old_id;
    while ($urandom_range(99) < send_idle_pct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i    <= 1'b1;
    kind_i     <= k;
    flag_id_i  <= f;
    instr_id_i <= iid;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    flag_model(k, f, iid, hit, old_id);
    if (fixed) begin
      hit    = fx_hit;
      old_id = fx_id;
    end
    if (hit) useless_ids_q.push_back(old_id);
  endtask

  task automatic wait_drained();
    valid_i <= 1'b0;
    while (useless_ids_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic add_row(input logic [KIND_W-1:0] k, input logic [FLAG_W-1:0] f,
                         input logic [IID_W-1:0] iid, input bit fixed,
                         input bit fx_hit, input logic [OUT_W-1:0] fx_id);
    instr_row_t r;
    r.kind   = k;
    r.flag   = f;
    r.iid    = iid;
    r.fixed  = fixed;
    r.fx_hit = fx_hit;
    r.fx_id  = fx_id;
    directed_q.push_back(r);
  endtask

  // result side: random stall, in-order compare, run limit
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
    stall_i <= ($urandom_range(99) < recv_stall_pct);
    if (rst_ni && valid_o && !stall_i) begin
      if (useless_ids_q.size() == 0) begin
        errors <= errors + 1;
        if (errors < MAX_REPORTS)
          $display("[%0d] unexpected result: useless_set_id=%h", cyc, useless_set_id_o);
      end else begin
        if (useless_set_id_o !== useless_ids_q[0]) begin
          errors <= errors + 1;
          if (errors < MAX_REPORTS)
            $display("[%0d] useless_set_id mismatch: expected %h, got %h",
                     cyc, useless_ids_q[0], useless_set_id_o);
        end
        void'(useless_ids_q.pop_front());
      end
    end
  end

  initial begin
    logic [KIND_W-1:0] k;
    logic [FLAG_W-1:0] f;
    logic [FLAG_W-1:0] base;
    logic [IID_W-1:0]  iid;
    logic [IID_W-1:0]  id_ctr;
    int                span;
    int                blk_len;
    int                roll;
    int                sent;

    // directed: special cases with obvious outcomes typed in
    add_row(KIND_GET,  4'd0,  16'h0001, 1, 0, '0);       // get with nothing pending
    add_row(KIND_SET,  4'd0,  16'h0002, 1, 0, '0);
    add_row(KIND_SET,  4'd0,  16'h0003, 1, 1, 16'h0002); // overwrite unread set
    add_row(KIND_GET,  4'd0,  16'h0004, 1, 0, '0);
    add_row(KIND_GET,  4'd0,  16'h0005, 1, 0, '0);       // repeated get
    add_row(KIND_SET,  4'd0,  16'h0006, 1, 0, '0);       // old set was read
    add_row(KIND_SET,  4'd15, 16'hFFFF, 1, 0, '0);
    add_row(KIND_SET,  4'd15, 16'h0000, 1, 1, 16'hFFFF);
    add_row(KIND_NONE, 4'd15, 16'h1234, 1, 0, '0);       // unused kind ignored
    add_row(KIND_SET,  4'd15, 16'h0010, 1, 1, 16'h0000);
    add_row(KIND_END,  4'd7,  16'hABCD, 1, 0, '0);       // fields ignored
    add_row(KIND_SET,  4'd15, 16'h0011, 1, 0, '0);       // block end cleared it
    add_row(KIND_SET,  4'd0,  16'h0012, 1, 0, '0);
    add_row(KIND_NONE, 4'd0,  16'hFFFF, 1, 0, '0);
    add_row(KIND_SET,  4'd8,  16'h5555, 1, 0, '0);
    add_row(KIND_SET,  4'd8,  16'hAAAA, 1, 1, 16'h5555); // back to back, same flag
    add_row(KIND_GET,  4'd8,  16'h0013, 1, 0, '0);
    add_row(KIND_SET,  4'd8,  16'h0020, 1, 0, '0);
    add_row(KIND_SET,  4'd7,  16'h0030, 1, 0, '0);
    add_row(KIND_GET,  4'd3,  16'h0031, 1, 0, '0);       // get on another flag
    add_row(KIND_SET,  4'd7,  16'h0032, 1, 1, 16'h0030);
    add_row(KIND_SET,  4'd1,  16'h0100, 0, 0, '0);
    add_row(KIND_SET,  4'd1,  16'h0101, 0, 0, '0);
    add_row(KIND_SET,  4'd0,  16'h0102, 0, 0, '0);
    add_row(KIND_END,  4'd15, 16'hFFFF, 0, 0, '0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct  = 23;
    recv_stall_pct = 55;
    foreach (directed_q[i])
      send_instr(directed_q[i].kind, directed_q[i].flag, directed_q[i].iid,
                 directed_q[i].fixed, directed_q[i].fx_hit, directed_q[i].fx_id);
    wait_drained();

    id_ctr = 16'($urandom);
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct  = (ph == 0) ? 23 : (ph == 1) ? 55 : 0;
      recv_stall_pct = (ph == 0) ? 55 : (ph == 1) ? 23 : 0;
      sent = 0;
      while (sent < RAND_PER_PHASE) begin
        // one basic block, mostly on a narrow window of flags, so overwrites are common
        blk_len = $urandom_range(1, 40);
        base    = 4'($urandom_range(15));
        span    = ($urandom_range(3) == 0) ? 15 : $urandom_range(3);
        for (int j = 0; j < blk_len; j++) begin
          roll = $urandom_range(99);
          if (roll < 5)       k = KIND_NONE;
          else if (roll < 55) k = KIND_SET;
          else if (roll < 95) k = KIND_GET;
          else                k = KIND_END;
          f      = base + 4'($urandom_range(span));
          id_ctr = id_ctr + 16'($urandom_range(1, 8));
          iid    = ($urandom_range(19) == 0) ? 16'($urandom) : id_ctr;
          send_instr(k, f, iid, 0, 0, '0);
          if (k != KIND_NONE) sent++;
        end
        send_instr(KIND_END, 4'($urandom), 16'($urandom), 0, 0, '0);
        sent++;
      end
      wait_drained();
    end

    if (errors == 0 && useless_ids_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
